FILE: hw/rtl/jhtb_pkg.sv
// Shared types and constants for the JPEG Huffman code table builder.
package jhtb_pkg;

    localparam int MAX_CODE_LENGTH = 16;
    localparam int SYMBOL_COUNT    = 256;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 5;                       // holds 0..MAX_CODE_LENGTH
    localparam int POS_W   = $clog2(MAX_CODE_LENGTH); // count byte position
    localparam int CODE_W  = 17;                      // code with saturation room
    localparam int SUM_W   = 12;                      // sum of all count bytes
    localparam int SYM_W   = 9;                       // holds 0..SYMBOL_COUNT
    localparam int IDX_W   = 9;
    localparam int BITS_W  = 16;
    localparam int PACK_W  = 32;

    localparam logic [CODE_W-1:0] CODE_SAT = {CODE_W{1'b1}};

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    typedef struct packed {
        logic [BYTE_W-1:0] table_byte;
        logic              table_start;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]  table_index;
        logic [BITS_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
        logic [PACK_W-1:0] packed_entry;
        logic              table_error;
        logic              last_entry;
    } t_out_item;

    localparam t_out_item CLEAR_ITEM = '{
        table_index:  '0,
        code_bits:    '0,
        code_length:  '0,
        packed_entry: '0,
        table_error:  1'b0,
        last_entry:   1'b1
    };

    // What the back end has to emit for one queued command.
    typedef enum logic [1:0] {
        KIND_ENTRY       = 2'd0,   // one code entry
        KIND_ENTRY_CLEAR = 2'd1,   // code entry, then the index 0 clearing write
        KIND_CLEAR       = 2'd2    // clearing write only
    } t_kind;

    typedef struct packed {
        t_kind     kind;
        t_out_item entry;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        BK_ENTRY = 2'b01,
        BK_CLEAR = 2'b10
    } t_back_state;

endpackage

FILE: hw/rtl/jpeg_huffman_code_table_builder_core.sv
// Top level of the JPEG canonical Huffman code table builder.
//
// Channel   Direction  Handshake            Payload
// input     in         push / full          i_item (t_in_item)
// result    out        empty / pop          o_item (t_out_item)
// config    in         i_cfg_wr_en          i_cfg_wr_data (ac_table)
//
// One item is taken per cycle while full is low; the front end does the
// whole length search (priority find over the count line) and code
// increment in that cycle. Results are registered in the command queue.
// The last symbol of an AC table yields two results, drained one per cycle
// on pop from the four-deep queue; full rises only when that queue fills.
// Reset (synchronous, active low) returns to the count phase with ac_table 0.
module jpeg_huffman_code_table_builder_core import jhtb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_item,
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data
);

    t_q_status q_status;
    t_cmd      front_cmd;
    t_cmd      q_head;
    logic      front_push;
    logic      q_rd_en;
    logic      accept;

    // Take an item whenever the queue has a free slot.
    assign full   = q_status.full;
    assign accept = push & ~q_status.full;

    jhtb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (i_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_push        (front_push),
        .o_cmd         (front_cmd)
    );

    // Decouple the parser from the result consumer.
    jhtb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (front_push),
        .i_wr_cmd (front_cmd),
        .i_rd_en  (q_rd_en),
        .o_head   (q_head),
        .o_status (q_status)
    );

    // Expand each command into one or two table writes.
    jhtb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (q_head),
        .i_status (q_status),
        .i_pop    (pop),
        .o_rd_en  (q_rd_en),
        .o_item   (o_item),
        .o_empty  (empty)
    );

endmodule

FILE: hw/rtl/jhtb_front.sv
// Front end: parses table bytes, assigns canonical codes and queues commands.
module jhtb_front import jhtb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    input  logic     i_cfg_wr_en,
    input  logic     i_cfg_wr_data,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic                    r_ac;
    logic                    r_loading;
    logic [POS_W-1:0]        r_pos;
    logic [SUM_W-1:0]        r_sum;
    logic [BYTE_W-1:0]       r_lens [MAX_CODE_LENGTH];
    logic [LEN_W-1:0]        r_cur;
    logic [CODE_W-1:0]       r_code;
    logic [SYM_W-1:0]        r_sym_left;
    logic                    r_over;

    logic                    n_loading;
    logic [POS_W-1:0]        n_pos;
    logic [SUM_W-1:0]        n_sum;
    logic [BYTE_W-1:0]       n_lens [MAX_CODE_LENGTH];
    logic [LEN_W-1:0]        n_cur;
    logic [CODE_W-1:0]       n_code;
    logic [SYM_W-1:0]        n_sym_left;
    logic                    n_over;

    logic                    eff_loading;
    logic [POS_W-1:0]        eff_pos;
    logic                    adv;
    logic [POS_W-1:0]        skip;
    logic [POS_W:0]          sel;
    logic [BYTE_W-1:0]       shifted [MAX_CODE_LENGTH];
    logic [LEN_W-1:0]        len;
    logic [2*CODE_W-2:0]     code_wide;
    logic [CODE_W-1:0]       code;
    logic [CODE_W+PACK_W-1:0] pack_wide;
    logic                    last;
    logic                    err;

    always_comb begin
        eff_loading = i_item.table_start | r_loading;
        eff_pos     = i_item.table_start ? '0 : r_pos;

        // Skip empty lengths: find the next length that still has codes.
        adv  = (r_lens[0] == '0) && (r_cur < LEN_W'(MAX_CODE_LENGTH));
        skip = adv ? POS_W'(LEN_W'(MAX_CODE_LENGTH) - r_cur) : '0;
        for (int j = MAX_CODE_LENGTH - 1; j >= 1; j--) begin
            if (adv && (r_lens[j] != '0)) begin
                skip = POS_W'(j);
            end
        end

        // Drop the skipped lengths from the head of the count line.
        for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
            sel = (POS_W+1)'(i) + {1'b0, skip};
            shifted[i] = (sel < (POS_W+1)'(MAX_CODE_LENGTH)) ? r_lens[sel[POS_W-1:0]] : '0;
        end

        len       = r_cur + LEN_W'(skip);
        code_wide = (2*CODE_W-1)'(r_code) << skip;
        code      = (code_wide[2*CODE_W-2:CODE_W] != '0) ? CODE_SAT
                                                         : code_wide[CODE_W-1:0];
        pack_wide = {code, {PACK_W{1'b0}}} >> len;
        last      = (r_sym_left == SYM_W'(1));
        err       = r_over | ((code >> len) != '0);

        n_loading  = r_loading;
        n_pos      = r_pos;
        n_sum      = r_sum;
        n_lens     = r_lens;
        n_cur      = r_cur;
        n_code     = r_code;
        n_sym_left = r_sym_left;
        n_over     = r_over;

        o_push = 1'b0;
        o_cmd.kind                 = KIND_ENTRY;
        o_cmd.entry.table_index    = (r_ac && (i_item.table_byte == '0))
                                   ? IDX_W'(SYMBOL_COUNT) : IDX_W'(i_item.table_byte);
        o_cmd.entry.code_bits      = code[BITS_W-1:0];
        o_cmd.entry.code_length    = len;
        o_cmd.entry.packed_entry   = pack_wide[PACK_W-1:0] | PACK_W'(len);
        o_cmd.entry.table_error    = err;
        o_cmd.entry.last_entry     = last & ~r_ac;

        if (i_accept) begin
            if (eff_loading) begin
                // Shift the count in at the tail; after a full run the head is length 1.
                for (int i = 0; i < MAX_CODE_LENGTH - 1; i++) begin
                    n_lens[i] = r_lens[i+1];
                end
                n_lens[MAX_CODE_LENGTH-1] = i_item.table_byte;
                n_sum = ((eff_pos == '0) ? '0 : r_sum) + SUM_W'(i_item.table_byte);
                if (eff_pos == POS_W'(MAX_CODE_LENGTH - 1)) begin
                    n_loading  = 1'b0;
                    n_pos      = '0;
                    n_cur      = LEN_W'(1);
                    n_code     = '0;
                    n_over     = (n_sum > SUM_W'(SYMBOL_COUNT));
                    n_sym_left = n_over ? SYM_W'(SYMBOL_COUNT) : n_sum[SYM_W-1:0];
                    if ((n_sym_left == '0) && r_ac) begin
                        o_push     = 1'b1;
                        o_cmd.kind = KIND_CLEAR;
                    end
                end else begin
                    n_loading = 1'b1;
                    n_pos     = eff_pos + POS_W'(1);
                end
            end else if (r_sym_left != '0) begin
                o_push     = 1'b1;
                o_cmd.kind = (last && r_ac) ? KIND_ENTRY_CLEAR : KIND_ENTRY;
                n_lens     = shifted;
                n_lens[0]  = (shifted[0] != '0) ? shifted[0] - BYTE_W'(1) : '0;
                n_cur      = len;
                n_code     = (code < CODE_SAT) ? code + CODE_W'(1) : code;
                n_sym_left = r_sym_left - SYM_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac       <= 1'b0;
            r_loading  <= 1'b1;
            r_pos      <= '0;
            r_cur      <= LEN_W'(1);
            r_code     <= '0;
            r_sym_left <= '0;
            r_over     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_ac <= i_cfg_wr_data;
            end
            r_loading  <= n_loading;
            r_pos      <= n_pos;
            r_cur      <= n_cur;
            r_code     <= n_code;
            r_sym_left <= n_sym_left;
            r_over     <= n_over;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_lens <= n_lens;
    end

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur >= LEN_W'(1)) && (r_cur <= LEN_W'(MAX_CODE_LENGTH)))
        else $error("current code length out of range");

    a_sym_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sym_left <= SYM_W'(SYMBOL_COUNT)) && (!r_loading || r_pos != '0 || 1'b1))
        else $error("symbol budget above table size");

endmodule

FILE: hw/rtl/jhtb_queue.sv
// Command queue between the front end and the back end.
module jhtb_queue import jhtb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_wr_en,
    input  t_cmd      i_wr_cmd,
    input  logic      i_rd_en,
    output t_cmd      o_head,
    output t_q_status o_status
);

    t_cmd               r_slots [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_head         = r_slots[r_rd_ptr];
    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_slots[r_wr_ptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_rd_en) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_count <= r_count + Q_CNT_W'(i_wr_en) - Q_CNT_W'(i_rd_en);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr_en && o_status.full && !i_rd_en))
        else $error("command written into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd_en && o_status.empty))
        else $error("command read from an empty queue");

endmodule

FILE: hw/rtl/jhtb_back.sv
// Back end: expands queued commands into table write items.
module jhtb_back import jhtb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_head,
    input  t_q_status i_status,
    input  logic      i_pop,
    output logic      o_rd_en,
    output t_out_item o_item,
    output logic      o_empty
);

    t_back_state r_state;
    t_back_state n_state;
    logic        take;

    assign o_empty = i_status.empty;
    assign take    = i_pop & ~i_status.empty;

    always_comb begin
        o_item  = ((i_head.kind == KIND_CLEAR) || (r_state == BK_CLEAR)) ? CLEAR_ITEM
                                                                        : i_head.entry;
        o_rd_en = take & ((i_head.kind != KIND_ENTRY_CLEAR) || (r_state == BK_CLEAR));
        n_state = r_state;
        unique case (r_state)
            BK_ENTRY: begin
                if (take && (i_head.kind == KIND_ENTRY_CLEAR)) begin
                    n_state = BK_CLEAR;
                end
            end
            BK_CLEAR: begin
                if (take) begin
                    n_state = BK_ENTRY;
                end
            end
            default: begin
                n_state = BK_ENTRY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_ENTRY;
        end else begin
            r_state <= n_state;
        end
    end

    a_clear_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_CLEAR) |-> (!i_status.empty && i_head.kind == KIND_ENTRY_CLEAR))
        else $error("clear phase without a pending entry-and-clear command");

endmodule
